@@ sv/pcmvm_pkg.sv @@
// Package: shared types and constants for the PCM voice pool mixer.
package pcmvm_pkg;

  localparam int DefVoices       = 32;
  localparam int DefSounds       = 256;
  localparam int DefSampleFrames = 65536;

  localparam logic [15:0] UNITY_GAIN = 16'd32768;
  localparam logic [16:0] MAX_FRAMES = 17'd65536;

  typedef enum logic [2:0] {
    FN_WRITE  = 3'd0,
    FN_DEFINE = 3'd1,
    FN_PLAY   = 3'd2,
    FN_STOP   = 3'd3,
    FN_GAIN   = 3'd4,
    FN_STOPALL = 3'd5,
    FN_TICK   = 3'd6,
    FN_NOP    = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_REPLY
  } state_t;

endpackage

@@ sv/pcm_voice_pool_mixer.sv @@
// Top level: PCM voice pool mixer with sample, sound and voice memories.
// Non-tick items: busy for one cycle; done is registered from ST_REPLY.
// Tick: one voice issued per cycle through a five-stage read/multiply/accumulate
// pipeline; after the last voice, ST_DRAIN empties the pipeline, then ST_REPLY.
// Receiver cannot stall; each result is shown for one cycle on done.
// Synchronous reset clears voice activity, sound definitions and sets unity master gain.
module pcm_voice_pool_mixer
  import pcmvm_pkg::*;
#(
  parameter int VOICES        = DefVoices,
  parameter int SOUNDS        = DefSounds,
  parameter int SAMPLE_FRAMES = DefSampleFrames
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         func,
  input  logic [7:0]         sound_num,
  input  logic [4:0]         voice_slot,
  input  logic signed [15:0] loop_count,
  input  logic [15:0]        voice_gain,
  input  logic [15:0]        sample_address,
  input  logic [16:0]        frame_count,
  input  logic signed [15:0] sample_left,
  input  logic signed [15:0] sample_right,
  input  logic               master_gain_we,
  input  logic [15:0]        master_gain,
  output logic               done,
  output logic signed [15:0] mix_left,
  output logic signed [15:0] mix_right,
  output logic signed [5:0]  play_slot,
  output logic [5:0]         active_voices
);

  localparam int VW  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SW  = $clog2(SOUNDS);
  localparam int AW  = $clog2(SAMPLE_FRAMES);
  localparam int SXW = SW + 8;
  localparam int VXW = VW + 5;
  localparam int SNW = AW + 17;

  state_t state, state_next;
  logic [VW:0] vidx;
  logic        accept;
  logic        issue;
  func_t       fn;

  logic [15:0] mgain;
  logic [VOICES-1:0] active;
  logic [SW-1:0]     vsound [VOICES];
  logic [15:0]       vgain  [VOICES];
  logic [SOUNDS-1:0] defined;

  logic [SXW-1:0] sid_full;
  logic [SW-1:0]  sid;
  logic           sid_ok;
  logic [VXW-1:0] slot_full;
  logic           slot_ok;
  logic [AW-1:0]  addr;
  logic [16:0]    frames_sat;

  logic          free_found;
  logic [VW-1:0] free_idx;
  logic signed [5:0] pslot;

  // memories
  logic           smp_we;
  logic [AW-1:0]  smp_waddr, smp_raddr;
  logic [31:0]    smp_wdata, smp_rdata;
  logic           snd_we;
  logic [SW-1:0]  snd_raddr;
  logic [SNW-1:0] snd_wdata, snd_rdata;
  logic           vc_we;
  logic [VW-1:0]  vc_waddr, vc_raddr;
  logic [32:0]    vc_wdata, vc_rdata;

  // pipeline
  logic          s1_valid;
  logic [VW-1:0] s1_v;
  logic [SW-1:0] s1_sid;
  logic [15:0]   s1_gain;
  logic          s2_valid;
  logic [15:0]   s2_gain;
  logic          s3_valid;
  logic signed [32:0] s3_pl, s3_pr;
  logic          s4_valid;
  logic signed [49:0] s4_pl, s4_pr;
  logic signed [15:0] acc_l, acc_r;

  logic [16:0] s1_frames, s1_pos, s1_rpos;
  logic [AW-1:0] s1_start;
  logic signed [15:0] s1_loops, s1_nloops;
  logic s1_fetch, s1_kill;

  logic signed [16:0] sc_l, sc_r;
  logic signed [15:0] acc_l_next, acc_r_next;

  assign fn        = func_t'(func);
  assign accept    = start && !busy;
  assign sid_full  = SXW'(sound_num);
  assign sid_ok    = (sid_full != '0) && (sid_full < SXW'(SOUNDS));
  assign sid       = sid_full[SW-1:0];
  assign slot_full = VXW'(voice_slot);
  assign slot_ok   = slot_full < VXW'(VOICES);
  assign addr      = AW'((AW + 16)'(sample_address));
  assign frames_sat = (frame_count > MAX_FRAMES) ? MAX_FRAMES : frame_count;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx   = VW'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (fn == FN_TICK) ? ST_RUN : ST_REPLY;
        end
      end
      ST_RUN: begin
        if (vidx == (VW + 1)'(VOICES - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_valid && !s2_valid && !s3_valid && !s4_valid) begin
          state_next = ST_REPLY;
        end
      end
      ST_REPLY: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = 1'b1;
    issue = 1'b0;
    case (state)
      ST_IDLE: busy  = 1'b0;
      ST_RUN:  issue = 1'b1;
      default: busy  = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vidx <= '0;
    end else if (accept) begin
      vidx <= '0;
    end else if (issue) begin
      vidx <= vidx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mgain <= UNITY_GAIN;
    end else if (master_gain_we) begin
      mgain <= (master_gain > UNITY_GAIN) ? UNITY_GAIN : master_gain;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      defined <= '0;
    end else if (accept && fn == FN_DEFINE && sid_ok) begin
      defined[sid] <= frames_sat != '0;
    end
  end

  // voice activity and per-voice registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else begin
      if (s1_kill) begin
        active[s1_v] <= 1'b0;
      end
      if (accept) begin
        case (fn)
          FN_PLAY: begin
            if (sid_ok && defined[sid] && free_found) begin
              active[free_idx] <= 1'b1;
            end
          end
          FN_STOP: begin
            if (slot_ok) begin
              active[slot_full[VW-1:0]] <= 1'b0;
            end
          end
          FN_STOPALL: active <= '0;
          default: active <= active;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && fn == FN_PLAY && sid_ok && defined[sid] && free_found) begin
      vsound[free_idx] <= sid;
      vgain[free_idx]  <= UNITY_GAIN;
    end else if (accept && fn == FN_GAIN && slot_ok) begin
      vgain[slot_full[VW-1:0]] <= (voice_gain > UNITY_GAIN) ? UNITY_GAIN : voice_gain;
    end
  end

  always_comb begin
    pslot = -6'sd1;
    if (fn == FN_PLAY && sid_ok && defined[sid] && free_found) begin
      pslot = $signed(6'((VW + 6)'(free_idx)));
    end
  end

  // memory ports
  assign smp_we    = accept && fn == FN_WRITE;
  assign smp_waddr = addr;
  assign smp_wdata = {sample_right, sample_left};
  assign snd_we    = accept && fn == FN_DEFINE && sid_ok;
  assign snd_wdata = {addr, frames_sat};
  assign snd_raddr = vsound[vidx[VW-1:0]];
  assign vc_raddr  = vidx[VW-1:0];

  pcmvm_ram #(.WIDTH(32), .DEPTH(SAMPLE_FRAMES)) u_sample_ram (
    .clk, .we(smp_we), .waddr(smp_waddr), .wdata(smp_wdata),
    .raddr(smp_raddr), .rdata(smp_rdata)
  );

  pcmvm_ram #(.WIDTH(SNW), .DEPTH(SOUNDS)) u_sound_ram (
    .clk, .we(snd_we), .waddr(sid), .wdata(snd_wdata),
    .raddr(snd_raddr), .rdata(snd_rdata)
  );

  pcmvm_ram #(.WIDTH(33), .DEPTH(1 << VW)) u_voice_ram (
    .clk, .we(vc_we), .waddr(vc_waddr), .wdata(vc_wdata),
    .raddr(vc_raddr), .rdata(vc_rdata)
  );

  // stage 1: voice update and sample fetch
  assign s1_frames = snd_rdata[16:0];
  assign s1_start  = snd_rdata[SNW-1:17];
  assign s1_pos    = vc_rdata[16:0];
  assign s1_loops  = $signed(vc_rdata[32:17]);

  always_comb begin
    s1_fetch  = 1'b0;
    s1_kill   = 1'b0;
    s1_rpos   = s1_pos;
    s1_nloops = s1_loops;
    if (s1_valid) begin
      if (!defined[s1_sid]) begin
        s1_kill = 1'b1;
      end else if (s1_pos >= s1_frames) begin
        if (s1_loops != 16'sd0) begin
          s1_fetch = 1'b1;
          s1_rpos  = '0;
          if (s1_loops > 16'sd0) begin
            s1_nloops = s1_loops - 16'sd1;
          end
        end else begin
          s1_kill = 1'b1;
        end
      end else begin
        s1_fetch = 1'b1;
      end
    end
  end

  always_comb begin
    vc_we     = 1'b0;
    vc_waddr  = s1_v;
    vc_wdata  = {s1_nloops, s1_rpos + 17'd1};
    smp_raddr = AW'((AW + 17)'(s1_start) + (AW + 17)'(s1_rpos));
    if (accept && fn == FN_PLAY) begin
      vc_we    = sid_ok && defined[sid] && free_found;
      vc_waddr = free_idx;
      vc_wdata = {loop_count, 17'd0};
    end else if (s1_fetch) begin
      vc_we = 1'b1;
    end
  end

  // stages 2 to 4: scale and accumulate
  always_comb begin
    sc_l = s4_pl < 0 ? -17'(((-s4_pl) >>> 30)) : 17'(s4_pl >>> 30);
    sc_r = s4_pr < 0 ? -17'(((-s4_pr) >>> 30)) : 17'(s4_pr >>> 30);
  end

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    r = v[15:0];
    if (v > 18'sd32767) begin
      r = 16'sd32767;
    end else if (v < -18'sd32768) begin
      r = -16'sd32768;
    end
    return r;
  endfunction

  assign acc_l_next = sat16(18'(acc_l) + 18'(sc_l));
  assign acc_r_next = sat16(18'(acc_r) + 18'(sc_r));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= issue && active[vidx[VW-1:0]];
      s2_valid <= s1_fetch;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_v    <= vidx[VW-1:0];
    s1_sid  <= vsound[vidx[VW-1:0]];
    s1_gain <= vgain[vidx[VW-1:0]];
    s2_gain <= s1_gain;
    s3_pl   <= $signed(smp_rdata[15:0])  * $signed({1'b0, s2_gain});
    s3_pr   <= $signed(smp_rdata[31:16]) * $signed({1'b0, s2_gain});
    s4_pl   <= s3_pl * $signed({1'b0, mgain});
    s4_pr   <= s3_pr * $signed({1'b0, mgain});
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc_l <= '0;
      acc_r <= '0;
    end else if (s4_valid) begin
      acc_l <= acc_l_next;
      acc_r <= acc_r_next;
    end
  end

  // hold play result until reply
  logic signed [5:0] pslot_q;
  always_ff @(posedge clk) begin
    if (accept) begin
      pslot_q <= pslot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= state == ST_REPLY;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_REPLY) begin
      mix_left      <= acc_l;
      mix_right     <= acc_r;
      play_slot     <= pslot_q;
      active_voices <= 6'($countones(active));
    end
  end

endmodule

@@ sv/pcmvm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pcmvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/pcmvm_checker.sv @@
// Port-level checker for the PCM voice pool mixer, bound to the top level.
module pcmvm_port_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic signed [5:0] play_slot,
  input logic [5:0]        active_voices
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after accept");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result beat while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("two result beats in a row");

  a_play_active: assert property (@(posedge clk) disable iff (rst)
    done && play_slot != -6'sd1 |-> active_voices != 6'd0)
    else $error("voice taken but none active");

endmodule

bind pcm_voice_pool_mixer pcmvm_port_checker u_pcmvm_checker (
  .clk, .rst, .start, .busy, .done, .play_slot, .active_voices
);

@@ tb/pcmvm_checker.sv @@
// Checker for the PCM voice pool mixer: tracks items, predicts each result beat, compares.
module pcmvm_checker
  import pcmvm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         func,
  input  logic [7:0]         sound_num,
  input  logic [4:0]         voice_slot,
  input  logic signed [15:0] loop_count,
  input  logic [15:0]        voice_gain,
  input  logic [15:0]        sample_address,
  input  logic [16:0]        frame_count,
  input  logic signed [15:0] sample_left,
  input  logic signed [15:0] sample_right,
  input  logic               master_gain_we,
  input  logic [15:0]        master_gain,
  input  logic               done,
  input  logic signed [15:0] mix_left,
  input  logic signed [15:0] mix_right,
  input  logic signed [5:0]  play_slot,
  input  logic [5:0]         active_voices,
  output int                 pending,
  output int                 fails
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] mixl;
    logic [15:0] mixr;
    logic [5:0]  slot;
    logic [5:0]  active;
  } mix_beat_t;

  bit [31:0] frame_mem [DefSampleFrames];
  bit [15:0] snd_start [DefSounds];
  bit [16:0] snd_frames [DefSounds];
  bit        snd_valid [DefSounds];
  bit [7:0]  vc_sound [DefVoices];
  bit [16:0] vc_pos [DefVoices];
  int        vc_loops [DefVoices];
  bit [15:0] vc_gain [DefVoices];
  bit [15:0] gain_master;
  mix_beat_t mix_q[$];

  initial begin
    pending = 0;
    fails = 0;
  end

  function automatic int clip16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int apply_gain(int s, int unsigned g);
    longint p;
    longint q;
    p = longint'(s) * longint'(g);
    q = (p < 0 ? -p : p) >>> 30;
    return int'(p < 0 ? -q : q);
  endfunction

  function automatic mix_beat_t mix_item();
    mix_beat_t r;
    int mixl;
    int mixr;
    int slot;
    int n;
    bit [7:0] s;
    bit [15:0] a;
    bit [31:0] w;
    int unsigned g;
    mixl = 0;
    mixr = 0;
    slot = -1;
    case (func_t'(func))
      FN_WRITE: frame_mem[sample_address] = {sample_right, sample_left};
      FN_DEFINE: begin
        if (sound_num != 0) begin
          snd_start[sound_num] = sample_address;
          snd_frames[sound_num] = frame_count > MAX_FRAMES ? MAX_FRAMES : frame_count;
          snd_valid[sound_num] = frame_count != 0;
        end
      end
      FN_PLAY: begin
        if (sound_num != 0 && snd_valid[sound_num]) begin
          for (int v = 0; v < DefVoices; v++) begin
            if (vc_sound[v] == 0) begin
              vc_sound[v] = sound_num;
              vc_pos[v] = 0;
              vc_loops[v] = int'(loop_count);
              vc_gain[v] = UNITY_GAIN;
              slot = v;
              break;
            end
          end
        end
      end
      FN_STOP: vc_sound[voice_slot] = 0;
      FN_GAIN: vc_gain[voice_slot] = voice_gain > UNITY_GAIN ? UNITY_GAIN : voice_gain;
      FN_STOPALL: foreach (vc_sound[v]) vc_sound[v] = 0;
      FN_TICK: begin
        for (int v = 0; v < DefVoices; v++) begin
          s = vc_sound[v];
          if (s == 0) continue;
          if (!snd_valid[s]) begin
            vc_sound[v] = 0;
            continue;
          end
          if (vc_pos[v] >= snd_frames[s]) begin
            if (vc_loops[v] != 0) begin
              if (vc_loops[v] > 0) vc_loops[v]--;
              vc_pos[v] = 0;
            end else begin
              vc_sound[v] = 0;
              continue;
            end
          end
          a = 16'(snd_start[s] + vc_pos[v]);
          w = frame_mem[a];
          g = int'(vc_gain[v]) * int'(gain_master);
          mixl = clip16(mixl + apply_gain(int'($signed(w[15:0])), g));
          mixr = clip16(mixr + apply_gain(int'($signed(w[31:16])), g));
          vc_pos[v]++;
        end
      end
      default: ;
    endcase
    n = 0;
    foreach (vc_sound[v]) if (vc_sound[v] != 0) n++;
    r.mixl = 16'(mixl);
    r.mixr = 16'(mixr);
    r.slot = 6'(slot);
    r.active = 6'(n);
    return r;
  endfunction

  always @(posedge clk) begin
    mix_beat_t e;
    if (rst) begin
      foreach (snd_valid[i]) snd_valid[i] = 0;
      foreach (vc_sound[v]) begin
        vc_sound[v] = 0;
        vc_pos[v] = 0;
        vc_loops[v] = 0;
        vc_gain[v] = 0;
      end
      gain_master = UNITY_GAIN;
      mix_q.delete();
    end else begin
      if (master_gain_we) gain_master = master_gain > UNITY_GAIN ? UNITY_GAIN : master_gain;
      if (done) begin
        if (mix_q.size() == 0) begin
          $error("result beat with no item outstanding");
          fails++;
        end else begin
          e = mix_q.pop_front();
          if (mix_left !== e.mixl) begin
            $error("mix_left expected %0d actual %0d", $signed(e.mixl), mix_left);
            fails++;
          end
          if (mix_right !== e.mixr) begin
            $error("mix_right expected %0d actual %0d", $signed(e.mixr), mix_right);
            fails++;
          end
          if (play_slot !== e.slot) begin
            $error("play_slot expected %0d actual %0d", $signed(e.slot), play_slot);
            fails++;
          end
          if (active_voices !== e.active) begin
            $error("active_voices expected %0d actual %0d", e.active, active_voices);
            fails++;
          end
        end
      end
      if (start && !busy) mix_q.push_back(mix_item());
    end
    pending = mix_q.size();
  end
endmodule

@@ tb/tb_top.sv @@
// Testbench top: clock, reset, item and master gain stimulus, watchdog and verdict.
module tb_top
  import pcmvm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 5000;

  typedef struct {
    logic [15:0] base;
    int          len;
  } region_t;

  logic               clk = 0;
  logic               rst = 1;
  logic               start = 0;
  logic               busy;
  logic [2:0]         func = 0;
  logic [7:0]         sound_num = 0;
  logic [4:0]         voice_slot = 0;
  logic signed [15:0] loop_count = 0;
  logic [15:0]        voice_gain = 0;
  logic [15:0]        sample_address = 0;
  logic [16:0]        frame_count = 0;
  logic signed [15:0] sample_left = 0;
  logic signed [15:0] sample_right = 0;
  logic               master_gain_we = 0;
  logic [15:0]        master_gain = 0;
  logic               done;
  logic signed [15:0] mix_left;
  logic signed [15:0] mix_right;
  logic signed [5:0]  play_slot;
  logic [5:0]         active_voices;
  int                 pending;
  int                 fails;
  int                 idle_cycles = 0;

  logic [7:0]  n_sid;
  logic [4:0]  n_slot;
  logic [15:0] n_loops, n_vgain, n_addr, n_left, n_right;
  logic [16:0] n_frames;
  int          burst_left = 0;
  region_t     regions[$];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  pcm_voice_pool_mixer dut (.*);

  pcmvm_checker u_checker (.*);

  always @(posedge clk) begin
    if ((start && !busy) || done || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic logic [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h7fff;
    if (r == 1) return 16'h8000;
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] pick_sound();
    return $urandom_range(0, 99) < 85 ? 8'($urandom_range(1, 12)) : 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] pick_loops();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 16'hffff;
    if (r < 50) return 16'd0;
    if (r < 80) return 16'($urandom_range(1, 3));
    return 16'($urandom);
  endfunction

  task automatic scramble();
    n_sid = 8'($urandom);
    n_slot = 5'($urandom);
    n_loops = 16'($urandom);
    n_vgain = 16'($urandom);
    n_addr = 16'($urandom);
    n_frames = 17'($urandom);
    n_left = 16'($urandom);
    n_right = 16'($urandom);
  endtask

  task automatic fire(func_t f);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    while (busy) @(negedge clk);
    func <= f;
    sound_num <= n_sid;
    voice_slot <= n_slot;
    loop_count <= n_loops;
    voice_gain <= n_vgain;
    sample_address <= n_addr;
    frame_count <= n_frames;
    sample_left <= n_left;
    sample_right <= n_right;
    start <= 1;
    @(negedge clk);
    start <= 0;
  endtask

  task automatic op(func_t f, logic [7:0] sid, logic [4:0] slot, logic [15:0] loops);
    scramble();
    n_sid = sid;
    n_slot = slot;
    n_loops = loops;
    fire(f);
  endtask

  task automatic define(logic [7:0] sid, logic [15:0] base, logic [16:0] frames);
    scramble();
    n_sid = sid;
    n_addr = base;
    n_frames = frames;
    fire(FN_DEFINE);
  endtask

  task automatic store_frame(logic [15:0] a, logic [15:0] l, logic [15:0] r);
    scramble();
    n_addr = a;
    n_left = l;
    n_right = r;
    fire(FN_WRITE);
  endtask

  task automatic set_gain(logic [4:0] slot, logic [15:0] g);
    scramble();
    n_slot = slot;
    n_vgain = g;
    fire(FN_GAIN);
  endtask

  task automatic write_master(logic [15:0] g);
    burst_left = 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    master_gain_we <= 1;
    master_gain <= g;
    @(negedge clk);
    master_gain_we <= 0;
    @(negedge clk);
  endtask

  task automatic fresh_region();
    region_t rg;
    rg.base = 16'($urandom);
    rg.len = $urandom_range(1, 6);
    for (int i = 0; i < rg.len; i++) store_frame(rg.base + 16'(i), pick_sample(), pick_sample());
    regions.push_back(rg);
    define(pick_sound(), rg.base, 17'($urandom_range(1, rg.len)));
  endtask

  task automatic random_item();
    int r;
    region_t rg;
    logic [7:0] sid;
    logic [15:0] g;
    r = $urandom_range(0, 99);
    if (r < 10) fresh_region();
    else if (r < 16) begin
      rg = regions[$urandom_range(0, regions.size() - 1)];
      define(pick_sound(), rg.base, 17'($urandom_range(0, rg.len)));
    end else if (r < 18) begin
      sid = 8'($urandom_range(1, 255));
      define(sid, 16'($urandom), 17'($urandom_range(65537, 131071)));
      define(sid, 16'($urandom), 17'd0);
    end else if (r < 20) define(8'd0, 16'($urandom), 17'($urandom));
    else if (r < 22) store_frame(16'($urandom), pick_sample(), pick_sample());
    else if (r < 44) op(FN_PLAY, pick_sound(), 5'($urandom), pick_loops());
    else if (r < 78) op(FN_TICK, 8'($urandom), 5'($urandom), 16'($urandom));
    else if (r < 85) op(FN_STOP, 8'($urandom), 5'($urandom), 16'($urandom));
    else if (r < 93) begin
      r = $urandom_range(0, 9);
      g = r == 0 ? UNITY_GAIN : r == 1 ? 16'd0 : 16'($urandom);
      set_gain(5'($urandom), g);
    end else if (r < 95) op(FN_STOPALL, 8'($urandom), 5'($urandom), 16'($urandom));
    else op(FN_NOP, 8'($urandom), 5'($urandom), 16'($urandom));
  endtask

  initial begin
    logic [15:0] phase_gain [6];
    region_t rg;
    phase_gain = '{16'd32768, 16'hffff, 16'd0, 16'd16384, 16'd1, 16'd0};
    phase_gain[5] = 16'($urandom);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);
    write_master(UNITY_GAIN);

    op(FN_TICK, 8'd0, 5'd0, 16'd0);
    store_frame(16'hffff, 16'h7fff, 16'h8000);
    store_frame(16'h0000, 16'h7fff, 16'h8000);
    store_frame(16'h0001, 16'hffff, 16'h0001);
    rg.base = 16'hffff;
    rg.len = 3;
    regions.push_back(rg);
    define(8'd1, 16'hffff, 17'd3);
    define(8'd0, 16'd0, 17'h1ffff);
    define(8'd255, 16'h1234, 17'h10005);
    define(8'd255, 16'h1234, 17'd0);
    op(FN_PLAY, 8'd255, 5'd0, 16'd0);
    op(FN_PLAY, 8'd0, 5'd0, 16'd0);
    op(FN_PLAY, 8'd1, 5'd0, 16'd0);
    op(FN_PLAY, 8'd1, 5'd0, 16'hffff);
    op(FN_PLAY, 8'd1, 5'd0, 16'h7fff);
    set_gain(5'd1, 16'hffff);
    set_gain(5'd31, 16'd100);
    repeat (4) op(FN_TICK, 8'd0, 5'd0, 16'd0);
    op(FN_STOP, 8'd0, 5'd0, 16'd0);
    op(FN_TICK, 8'd0, 5'd0, 16'd0);
    define(8'd1, 16'hffff, 17'd0);
    op(FN_TICK, 8'd0, 5'd0, 16'd0);
    op(FN_NOP, 8'd1, 5'd2, 16'd0);
    op(FN_STOPALL, 8'd0, 5'd0, 16'd0);
    op(FN_TICK, 8'd0, 5'd0, 16'd0);

    foreach (phase_gain[p]) begin
      write_master(phase_gain[p]);
      repeat (220) random_item();
    end

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule
